// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds now, consequent holds in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle property");

// antecedent and consequent hold in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle property");

`endif

// ===== hw/rtl/tlst_pkg.sv =====
// Shared types, widths, codes and the sigmoid table for the sigmoid trainer.
// No dependencies; the core, lane and sigmoid files refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tlst_pkg;

    localparam int WEIGHT_BITS   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int SIG_LUT_DEPTH = 1024;

    localparam int XW      = 17;
    localparam int LRW     = 16;
    localparam int LR_FRAC = 16;
    localparam int CFGW    = 17;
    localparam int CIDXW   = 3;
    localparam int OPW     = 2;
    localparam int NETW    = 17;
    localparam int OERRW   = 18;

    localparam logic [OPW-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPW-1:0] OP_TRAIN = 2'd1;
    localparam logic [OPW-1:0] OP_INFER = 2'd2;

    localparam logic [CIDXW-1:0] REG_LEARN_RATE = 3'd0;
    localparam logic [CIDXW-1:0] REG_OUT_W0     = 3'd1;
    localparam logic [CIDXW-1:0] REG_OUT_W1     = 3'd2;
    localparam logic [CIDXW-1:0] REG_AND_W0     = 3'd3;
    localparam logic [CIDXW-1:0] REG_AND_W1     = 3'd4;
    localparam logic [CIDXW-1:0] REG_OR_W0      = 3'd5;
    localparam logic [CIDXW-1:0] REG_OR_W1      = 3'd6;

    localparam int YW    = FRAC_BITS + 1;
    localparam int ERR_W = FRAC_BITS + 4;
    localparam longint ONE_Q = longint'(1) << FRAC_BITS;

    localparam int M1W   = (WEIGHT_BITS > ERR_W) ? WEIGHT_BITS : ERR_W;
    localparam int M2A   = (XW > YW) ? XW : YW;
    localparam int M2W   = (M2A > LRW) ? M2A : LRW;
    localparam int PRW   = M1W + M2W;
    localparam int MINSH = (FRAC_BITS < LR_FRAC) ? FRAC_BITS : LR_FRAC;
    localparam int MGW   = PRW - MINSH;
    localparam int PW    = MGW + 1;
    localparam int SW    = ((PW > WEIGHT_BITS) ? PW : WEIGHT_BITS) + 2;

    localparam longint SIG_C    = longint'(30) << FRAC_BITS;
    localparam int     CW       = $clog2(SIG_C + 1);
    localparam longint SIG_NMAX = SIG_C * SIG_LUT_DEPTH + SIG_C / 2;
    localparam int     NW       = $clog2(SIG_NMAX + 1);
    localparam int     RK       = NW + CW;
    localparam int     RW       = NW + 1;
    localparam logic [127:0] RK_POW = 128'd1 << RK;
    localparam logic [127:0] RECIP  = (RK_POW + 128'(SIG_C) - 128'd1) / 128'(SIG_C);
    localparam int     QW       = NW + RW - RK;
    localparam int     IXW      = $clog2(SIG_LUT_DEPTH + 1);

    typedef logic [YW-1:0] sig_lut_t [0:SIG_LUT_DEPTH];

    typedef struct packed {
        logic fwd;
        logic upd;
        logic train;
        logic load;
    } lane_cmd_t;

    typedef struct packed {
        logic fwd_done;
        logic busy;
    } lane_stat_t;

    // shift and subtract long division, used only while building the table
    function automatic logic [127:0] long_div(input logic [127:0] num,
                                              input logic [127:0] den);
        logic [127:0] q;
        logic [128:0] r;
        int           k;
        q = '0;
        r = '0;
        for (k = 127; k >= 0; k--)
        begin
            r = {r[127:0], num[k]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sig_lut_t build_sig_lut();
        logic [127:0] t;
        logic [127:0] e;
        logic [127:0] d;
        logic [127:0] p;
        logic [127:0] den;
        logic [127:0] num;
        sig_lut_t     r;
        int           n;
        int           i;
        t = 128'd1 << 32;
        e = t;
        p = 128'd1 << 32;
        for (n = 1; n <= 12; n++)
        begin
            t = long_div(t * 128'd30, 128'(SIG_LUT_DEPTH) * 128'(n));
            e = e + t;
        end
        d = long_div((128'd1 << 64) - 128'd1, e);
        for (i = 0; i <= SIG_LUT_DEPTH; i++)
        begin
            den  = (128'd1 << 32) + p;
            num  = (128'(ONE_Q) << 32) + (den >> 1);
            r[i] = YW'(long_div(num, den));
            p    = (p * d) >> 32;
        end
        return r;
    endfunction

    localparam sig_lut_t SIG_LUT = build_sig_lut();

    localparam logic signed [SW-1:0] W_MAX_S = (SW'(1) <<< (WEIGHT_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] W_MIN_S = -(SW'(1) <<< (WEIGHT_BITS - 1));

    function automatic logic signed [WEIGHT_BITS-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        c = v;
        if (v > W_MAX_S)
        begin
            c = W_MAX_S;
        end
        else if (v < W_MIN_S)
        begin
            c = W_MIN_S;
        end
        return c[WEIGHT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/two_layer_sigmoid_trainer_core.sv =====
// Top level of the 2-2-1 sigmoid trainer: configuration registers, item
// sequencer, two hidden lanes, the output lane and the result register.
// Depends on tlst_pkg and tlst_lane.
//
// Usage:
//   Requests arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tuser carries the
//   opcode (load, train, infer), s_tdata the two inputs and the goal.
//   Each request gives exactly one result on m_tvalid/m_tready/m_tdata.
//   The AND and OR lanes run side by side; the output lane then merges their
//   sigmoid outputs. Each lane owns one multiplier and one sigmoid pipeline.
//   Infer and train run the chain hidden lane, then output lane; train adds
//   the update steps (three multiply and sum steps and the sigmoid pipeline
//   per lane for the forward pass, five update steps per lane, plus the
//   sequencer handoff states). Load only reloads the weights and biases.
//   One request is in work at a time; the next can be accepted in the same
//   cycle that a result is issued.
//   s_tready rises again once the request is finished and parked in the
//   result register; a stalled receiver holds that result, and the next
//   request may be accepted and worked on meanwhile, stopping at its result.
//   Reset clears weights to zero, biases to one half and configuration to
//   its defaults; it drops any pending result.
//   Issue configuration writes (cfg_we, cfg_idx, cfg_data) only while idle.
`timescale 1ns / 1ps
`default_nettype none

module two_layer_sigmoid_trainer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // x_first[16:0], x_second[33:17], goal[50:34], zero pad
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // net_out[16:0], out_error[34:17], zero pad
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [16:0] cfg_data
);

    localparam int XW  = tlst_pkg::XW;
    localparam int YW  = tlst_pkg::YW;
    localparam int EW  = tlst_pkg::ERR_W;
    localparam int TW  = 2 * XW - tlst_pkg::FRAC_BITS;
    localparam int EIA = (TW > YW) ? TW : YW;
    localparam int EIW = ((EIA > XW) ? EIA : XW) + 3;

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_START = 3'd1;
    localparam logic [2:0] T_HID   = 3'd2;
    localparam logic [2:0] T_OUT   = 3'd3;
    localparam logic [2:0] T_UPD   = 3'd4;
    localparam logic [2:0] T_FIN   = 3'd5;

    localparam logic [tlst_pkg::CFGW-1:0] INIT_W_RST = 17'd32768;
    localparam logic signed [EIW-1:0] OE_MAX = (EIW'(1) <<< (tlst_pkg::OERRW - 1)) - EIW'(1);
    localparam logic signed [EIW-1:0] OE_MIN = -(EIW'(1) <<< (tlst_pkg::OERRW - 1));
    localparam logic [YW:0] NET_MAX = (YW + 1)'((longint'(1) << tlst_pkg::NETW) - 1);

    logic [2:0] st_reg;
    logic [2:0] st_next;

    logic [tlst_pkg::LRW-1:0]  lr_reg;
    logic [tlst_pkg::CFGW-1:0] iw_reg [0:5];

    logic [tlst_pkg::OPW-1:0] op_reg;
    logic [XW-1:0]            x0_reg;
    logic [XW-1:0]            x1_reg;
    logic [XW-1:0]            goal_reg;
    logic [TW-1:0]            tand_reg;
    logic [YW-1:0]            yout_reg;
    logic signed [EIW-1:0]    eout_reg;

    logic                         m_vld_reg;
    logic [tlst_pkg::NETW-1:0]    net_reg;
    logic [tlst_pkg::OERRW-1:0]   oerr_reg;

    tlst_pkg::lane_cmd_t  hid_cmd;
    tlst_pkg::lane_cmd_t  out_cmd;
    tlst_pkg::lane_stat_t and_stat;
    tlst_pkg::lane_stat_t or_stat;
    tlst_pkg::lane_stat_t out_stat;

    logic [YW-1:0] y_and;
    logic [YW-1:0] y_or;
    logic [YW-1:0] y_out;

    logic signed [EW-1:0] e_and;
    logic signed [EW-1:0] e_or;
    logic signed [EW-1:0] e_out;
    logic signed [EIW-1:0] ei_and;
    logic signed [EIW-1:0] ei_or;
    logic signed [EIW-1:0] ei_out;

    logic [tlst_pkg::M2W-1:0] hid_a;
    logic [tlst_pkg::M2W-1:0] hid_b;
    logic [tlst_pkg::M2W-1:0] out_a;
    logic [tlst_pkg::M2W-1:0] out_b;

    logic s_acc;
    logic fin_go;
    logic is_train;
    logic [YW:0] y_wide;
    logic signed [EIW-1:0] oe_sat;

    assign s_tready = (st_reg == T_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign fin_go   = (st_reg == T_FIN) && (!m_vld_reg || m_tready);
    assign is_train = (op_reg == tlst_pkg::OP_TRAIN);

    assign hid_a = tlst_pkg::M2W'(x0_reg);
    assign hid_b = tlst_pkg::M2W'(x1_reg);
    assign out_a = tlst_pkg::M2W'(y_and);
    assign out_b = tlst_pkg::M2W'(y_or);

    always_comb
    begin
        ei_and = EIW'(signed'({1'b0, tand_reg})) - EIW'(signed'({1'b0, y_and}));
        ei_or  = EIW'(signed'({1'b0, x0_reg})) + EIW'(signed'({1'b0, x1_reg}))
                 - EIW'(signed'({1'b0, tand_reg})) - EIW'(signed'({1'b0, y_or}));
        ei_out = EIW'(signed'({1'b0, goal_reg})) - EIW'(signed'({1'b0, y_out}));
        e_and  = ei_and[EW-1:0];
        e_or   = ei_or[EW-1:0];
        e_out  = ei_out[EW-1:0];

        hid_cmd       = '0;
        out_cmd       = '0;
        hid_cmd.train = is_train;
        out_cmd.train = is_train;
        st_next       = st_reg;
        unique case (st_reg)
            T_IDLE:
            begin
                if (s_acc)
                begin
                    st_next = T_START;
                end
            end
            T_START:
            begin
                if (op_reg == tlst_pkg::OP_LOAD)
                begin
                    hid_cmd.load = 1'b1;
                    out_cmd.load = 1'b1;
                    st_next      = T_FIN;
                end
                else
                begin
                    hid_cmd.fwd = 1'b1;
                    st_next     = T_HID;
                end
            end
            T_HID:
            begin
                if (and_stat.fwd_done && or_stat.fwd_done)
                begin
                    out_cmd.fwd = 1'b1;
                    hid_cmd.upd = 1'b1;
                    st_next     = T_OUT;
                end
            end
            T_OUT:
            begin
                if (out_stat.fwd_done)
                begin
                    out_cmd.upd = 1'b1;
                    st_next     = T_UPD;
                end
            end
            T_UPD:
            begin
                if (!and_stat.busy && !or_stat.busy && !out_stat.busy)
                begin
                    st_next = T_FIN;
                end
            end
            T_FIN:
            begin
                if (fin_go)
                begin
                    st_next = T_IDLE;
                end
            end
            default: st_next = T_IDLE;
        endcase

        y_wide = (YW + 1)'(yout_reg);
        if (y_wide > NET_MAX)
        begin
            y_wide = NET_MAX;
        end
        oe_sat = eout_reg;
        if (eout_reg > OE_MAX)
        begin
            oe_sat = OE_MAX;
        end
        else if (eout_reg < OE_MIN)
        begin
            oe_sat = OE_MIN;
        end
    end

    tlst_lane u_and (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (hid_cmd),
        .a          (hid_a),
        .b          (hid_b),
        .err        (e_and),
        .learn_rate (lr_reg),
        .init_w0    (iw_reg[2]),
        .init_w1    (iw_reg[3]),
        .y          (y_and),
        .stat       (and_stat)
    );

    tlst_lane u_or (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (hid_cmd),
        .a          (hid_a),
        .b          (hid_b),
        .err        (e_or),
        .learn_rate (lr_reg),
        .init_w0    (iw_reg[4]),
        .init_w1    (iw_reg[5]),
        .y          (y_or),
        .stat       (or_stat)
    );

    tlst_lane u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (out_cmd),
        .a          (out_a),
        .b          (out_b),
        .err        (e_out),
        .learn_rate (lr_reg),
        .init_w0    (iw_reg[0]),
        .init_w1    (iw_reg[1]),
        .y          (y_out),
        .stat       (out_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= T_IDLE;
            m_vld_reg <= 1'b0;
            lr_reg    <= 16'd1966;
            for (int i = 0; i < 6; i++)
            begin
                iw_reg[i] <= INIT_W_RST;
            end
        end
        else
        begin
            st_reg <= st_next;
            if (fin_go)
            begin
                m_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_vld_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    tlst_pkg::REG_LEARN_RATE: lr_reg    <= cfg_data[tlst_pkg::LRW-1:0];
                    tlst_pkg::REG_OUT_W0:     iw_reg[0] <= cfg_data;
                    tlst_pkg::REG_OUT_W1:     iw_reg[1] <= cfg_data;
                    tlst_pkg::REG_AND_W0:     iw_reg[2] <= cfg_data;
                    tlst_pkg::REG_AND_W1:     iw_reg[3] <= cfg_data;
                    tlst_pkg::REG_OR_W0:      iw_reg[4] <= cfg_data;
                    tlst_pkg::REG_OR_W1:      iw_reg[5] <= cfg_data;
                    default:                  lr_reg    <= lr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            op_reg   <= s_tuser;
            x0_reg   <= s_tdata[16:0];
            x1_reg   <= s_tdata[33:17];
            goal_reg <= s_tdata[50:34];
        end
        if (st_reg == T_START)
        begin
            tand_reg <= TW'((2 * XW)'(x0_reg * x1_reg) >> tlst_pkg::FRAC_BITS);
            yout_reg <= '0;
            eout_reg <= '0;
        end
        if ((st_reg == T_OUT) && out_stat.fwd_done)
        begin
            yout_reg <= y_out;
            eout_reg <= is_train ? ei_out : '0;
        end
        if (fin_go)
        begin
            net_reg  <= y_wide[tlst_pkg::NETW-1:0];
            oerr_reg <= oe_sat[tlst_pkg::OERRW-1:0];
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {5'd0, oerr_reg, net_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/tlst_sigmoid.sv =====
// Four-stage sigmoid: clamp and scale, reciprocal multiply, table read, sign fold.
// Depends on tlst_pkg for widths, the reciprocal and the table.
`timescale 1ns / 1ps
`default_nettype none

module tlst_sigmoid (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    input  wire logic signed [tlst_pkg::SW-1:0]   s,
    output logic                                  out_valid,
    output logic [tlst_pkg::YW-1:0]               y
);

    localparam logic signed [tlst_pkg::SW-1:0] C_POS = tlst_pkg::SW'(tlst_pkg::SIG_C);
    localparam logic signed [tlst_pkg::SW-1:0] C_NEG = -tlst_pkg::SW'(tlst_pkg::SIG_C);
    localparam logic [tlst_pkg::NW-1:0] N_OFS = tlst_pkg::NW'(tlst_pkg::SIG_C / 2);
    localparam logic [tlst_pkg::NW-1:0] N_DEP = tlst_pkg::NW'(tlst_pkg::SIG_LUT_DEPTH);
    localparam logic [tlst_pkg::QW-1:0] Q_DEP = tlst_pkg::QW'(tlst_pkg::SIG_LUT_DEPTH);
    localparam logic [tlst_pkg::RW-1:0] RCP   = tlst_pkg::RECIP[tlst_pkg::RW-1:0];
    localparam logic [tlst_pkg::YW-1:0] ONE_Y = tlst_pkg::YW'(tlst_pkg::ONE_Q);

    logic [3:0] vld_reg;

    logic signed [tlst_pkg::SW-1:0] sc;
    logic signed [tlst_pkg::SW-1:0] sa;
    logic [tlst_pkg::NW-1:0]        n_next;

    logic [tlst_pkg::NW-1:0]         n_reg;
    logic [tlst_pkg::NW+tlst_pkg::RW-1:0] q_reg;
    logic [tlst_pkg::QW-1:0]         iq;
    logic [tlst_pkg::IXW-1:0]        idx;
    logic [tlst_pkg::YW-1:0]         t_reg;
    logic [tlst_pkg::YW-1:0]         y_reg;
    logic [2:0]                      neg_reg;

    always_comb
    begin
        sc = s;
        if (s > C_POS)
        begin
            sc = C_POS;
        end
        else if (s < C_NEG)
        begin
            sc = C_NEG;
        end
        sa     = (sc < 0) ? -sc : sc;
        n_next = sa[tlst_pkg::NW-1:0] * N_DEP + N_OFS;
        iq     = q_reg[tlst_pkg::NW+tlst_pkg::RW-1:tlst_pkg::RK];
        idx    = (iq > Q_DEP) ? Q_DEP[tlst_pkg::IXW-1:0] : iq[tlst_pkg::IXW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        neg_reg <= {neg_reg[1:0], (s < 0)};
        q_reg   <= n_reg * RCP;
        t_reg   <= tlst_pkg::SIG_LUT[idx];
        y_reg   <= neg_reg[2] ? (ONE_Y - t_reg) : t_reg;
    end

    assign out_valid = vld_reg[3];
    assign y         = y_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tlst_lane.sv =====
// One neuron lane: two weights and a bias, a shared multiplier, a sigmoid unit
// and a small sequencer for the forward pass and the delta-rule update.
// Depends on tlst_pkg and tlst_sigmoid.
`timescale 1ns / 1ps
`default_nettype none

module tlst_lane (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire tlst_pkg::lane_cmd_t                   cmd,
    input  wire logic [tlst_pkg::M2W-1:0]              a,
    input  wire logic [tlst_pkg::M2W-1:0]              b,
    input  wire logic signed [tlst_pkg::ERR_W-1:0]     err,
    input  wire logic [tlst_pkg::LRW-1:0]              learn_rate,
    input  wire logic [tlst_pkg::CFGW-1:0]             init_w0,
    input  wire logic [tlst_pkg::CFGW-1:0]             init_w1,
    output logic [tlst_pkg::YW-1:0]                    y,
    output tlst_pkg::lane_stat_t                       stat
);

    localparam int WB = tlst_pkg::WEIGHT_BITS;
    localparam logic signed [WB-1:0] HALF = WB'(tlst_pkg::ONE_Q / 2);

    localparam logic [3:0] L_IDLE = 4'd0;
    localparam logic [3:0] L_MA   = 4'd1;
    localparam logic [3:0] L_MB   = 4'd2;
    localparam logic [3:0] L_SUM  = 4'd3;
    localparam logic [3:0] L_SIG  = 4'd4;
    localparam logic [3:0] L_WAIT = 4'd5;
    localparam logic [3:0] L_KE   = 4'd6;
    localparam logic [3:0] L_KR   = 4'd7;
    localparam logic [3:0] L_UA   = 4'd8;
    localparam logic [3:0] L_UB   = 4'd9;
    localparam logic [3:0] L_UW   = 4'd10;

    logic [3:0] st_reg;
    logic [3:0] st_next;

    logic signed [WB-1:0] w0_reg;
    logic signed [WB-1:0] w1_reg;
    logic signed [WB-1:0] bias_reg;

    logic [tlst_pkg::M2W-1:0]          a_reg;
    logic [tlst_pkg::M2W-1:0]          b_reg;
    logic signed [tlst_pkg::ERR_W-1:0] err_reg;
    logic [tlst_pkg::M1W-1:0]          ke_mag_reg;
    logic                              ke_neg_reg;
    logic [tlst_pkg::PRW-1:0]          prod_reg;
    logic                              neg_reg;
    logic signed [tlst_pkg::PW-1:0]    p0_reg;
    logic signed [tlst_pkg::SW-1:0]    s_reg;
    logic                              s_vld_reg;
    logic [tlst_pkg::YW-1:0]           y_reg;

    logic [tlst_pkg::M1W-1:0]       op1;
    logic [tlst_pkg::M2W-1:0]       op2;
    logic                           neg_next;
    logic [WB-1:0]                  w0_mag;
    logic [WB-1:0]                  w1_mag;
    logic signed [tlst_pkg::ERR_W-1:0] err_abs;
    logic [tlst_pkg::PRW-1:0]       sh_f;
    logic [tlst_pkg::PRW-1:0]       sh_k;
    logic signed [tlst_pkg::PW-1:0] mag_f;
    logic signed [tlst_pkg::PW-1:0] sval_f;
    logic signed [tlst_pkg::SW-1:0] ke_s;

    logic                    sig_vld;
    logic [tlst_pkg::YW-1:0] sig_y;

    tlst_sigmoid u_sig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_vld_reg),
        .s         (s_reg),
        .out_valid (sig_vld),
        .y         (sig_y)
    );

    always_comb
    begin
        w0_mag  = (w0_reg < 0) ? WB'(-w0_reg) : WB'(w0_reg);
        w1_mag  = (w1_reg < 0) ? WB'(-w1_reg) : WB'(w1_reg);
        err_abs = (err_reg < 0) ? -err_reg : err_reg;
        sh_f    = prod_reg >> tlst_pkg::FRAC_BITS;
        sh_k    = prod_reg >> tlst_pkg::LR_FRAC;
        mag_f   = signed'({1'b0, sh_f[tlst_pkg::MGW-1:0]});
        sval_f  = neg_reg ? -mag_f : mag_f;
        ke_s    = tlst_pkg::SW'(signed'({1'b0, ke_mag_reg}));
        if (ke_neg_reg)
        begin
            ke_s = -ke_s;
        end
        op1      = '0;
        op2      = '0;
        neg_next = 1'b0;
        case (st_reg)
            L_MA:
            begin
                op1      = tlst_pkg::M1W'(w0_mag);
                op2      = a_reg;
                neg_next = w0_reg < 0;
            end
            L_MB:
            begin
                op1      = tlst_pkg::M1W'(w1_mag);
                op2      = b_reg;
                neg_next = w1_reg < 0;
            end
            L_KE:
            begin
                op1      = tlst_pkg::M1W'(unsigned'(err_abs));
                op2      = tlst_pkg::M2W'(learn_rate);
                neg_next = err_reg < 0;
            end
            L_UA:
            begin
                op1      = ke_mag_reg;
                op2      = a_reg;
                neg_next = ke_neg_reg;
            end
            L_UB:
            begin
                op1      = ke_mag_reg;
                op2      = b_reg;
                neg_next = ke_neg_reg;
            end
            default:
            begin
                op1 = '0;
            end
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            L_IDLE: st_next = cmd.fwd ? L_MA : L_IDLE;
            L_MA:   st_next = L_MB;
            L_MB:   st_next = L_SUM;
            L_SUM:  st_next = L_SIG;
            L_SIG:  st_next = sig_vld ? L_WAIT : L_SIG;
            L_WAIT:
            begin
                if (cmd.upd)
                begin
                    st_next = cmd.train ? L_KE : L_IDLE;
                end
            end
            L_KE:   st_next = L_KR;
            L_KR:   st_next = L_UA;
            L_UA:   st_next = L_UB;
            L_UB:   st_next = L_UW;
            L_UW:   st_next = L_IDLE;
            default: st_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= L_IDLE;
            s_vld_reg <= 1'b0;
            w0_reg    <= '0;
            w1_reg    <= '0;
            bias_reg  <= HALF;
        end
        else
        begin
            st_reg    <= st_next;
            s_vld_reg <= (st_reg == L_SUM);
            if ((st_reg == L_IDLE) && cmd.load)
            begin
                w0_reg   <= WB'(init_w0);
                w1_reg   <= WB'(init_w1);
                bias_reg <= HALF;
            end
            if (st_reg == L_UA)
            begin
                bias_reg <= tlst_pkg::sat_w(tlst_pkg::SW'(bias_reg) - ke_s);
            end
            if (st_reg == L_UB)
            begin
                w0_reg <= tlst_pkg::sat_w(tlst_pkg::SW'(w0_reg) + tlst_pkg::SW'(sval_f));
            end
            if (st_reg == L_UW)
            begin
                w1_reg <= tlst_pkg::sat_w(tlst_pkg::SW'(w1_reg) + tlst_pkg::SW'(sval_f));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op1 * op2;
        neg_reg  <= neg_next;
        if ((st_reg == L_IDLE) && cmd.fwd)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (st_reg == L_MB)
        begin
            p0_reg <= sval_f;
        end
        if (st_reg == L_SUM)
        begin
            s_reg <= tlst_pkg::SW'(p0_reg) + tlst_pkg::SW'(sval_f) - tlst_pkg::SW'(bias_reg);
        end
        if ((st_reg == L_SIG) && sig_vld)
        begin
            y_reg <= sig_y;
        end
        if ((st_reg == L_WAIT) && cmd.upd)
        begin
            err_reg <= err;
        end
        if (st_reg == L_KR)
        begin
            ke_mag_reg <= sh_k[tlst_pkg::M1W-1:0];
            ke_neg_reg <= neg_reg;
        end
    end

    assign y             = y_reg;
    assign stat.fwd_done = (st_reg == L_WAIT);
    assign stat.busy     = (st_reg != L_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/tlst_checker.sv =====
// Port-level checks for the sigmoid trainer core, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlst_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // a result waiting on the receiver must hold
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one request in work at a time: acceptance drops ready
    `ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)
    // sigmoid output never exceeds one
    `ASSERT_SAME(a_net_range, m_tvalid, m_tdata[16:0] <= 17'd65536)

endmodule

bind two_layer_sigmoid_trainer_core tlst_checker u_tlst_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for two_layer_sigmoid_trainer_core: directed table, then random
// load/train/infer and spare-opcode requests over several weight and learning-rate settings.
// Depends on tlst_pkg (codes, widths) and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam logic [tlst_pkg::OPW-1:0] OP_SPARE = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE = 40;
    localparam int DEPTH = tlst_pkg::SIG_LUT_DEPTH;
    localparam longint ONE = tlst_pkg::ONE_Q;
    localparam int FB = tlst_pkg::FRAC_BITS;

    typedef struct packed {
        logic [16:0] net;
        logic [17:0] err;
    } result_t;

    typedef struct {
        logic [1:0]  op;
        logic [16:0] xa;
        logic [16:0] xb;
        logic [16:0] goal;
        bit          typed;
        logic [16:0] net;
        logic [17:0] err;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [16:0] cfg_data = '0;

    two_layer_sigmoid_trainer_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // network model state
    longint unsigned sig_tab [0:DEPTH];
    longint unsigned rate_k;
    longint unsigned seed_w [6];
    longint          net_w [6];
    longint          net_b [3];

    result_t pending_results [$];
    bit      cur_typed = 0;
    result_t cur_result;
    int      fail_count = 0;
    int      req_count = 0;
    int      rsp_count = 0;
    int      train_count = 0;
    int      idle_cycles = 0;
    int      cyc = 0;
    int      stall_mod = 17;

    function automatic void fill_sig_tab();
        longint unsigned t;
        longint unsigned e;
        longint unsigned d;
        longint unsigned p;
        longint unsigned den;
        t = 64'd1 << 32;
        e = t;
        p = 64'd1 << 32;
        for (int n = 1; n <= 12; n++)
        begin
            t = t * 30 / (longint'(DEPTH) * n);
            e += t;
        end
        d = 64'hFFFF_FFFF_FFFF_FFFF / e;
        for (int i = 0; i <= DEPTH; i++)
        begin
            den = (64'd1 << 32) + p;
            sig_tab[i] = ((longint'(ONE) << 32) + den / 2) / den;
            p = (p * d) >> 32;
        end
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint clip_w(longint v);
        return clip(v, -(64'sd1 <<< (tlst_pkg::WEIGHT_BITS - 1)),
                    (64'sd1 <<< (tlst_pkg::WEIGHT_BITS - 1)) - 1);
    endfunction

    function automatic longint qmul(longint a, longint b, int sh);
        bit              neg;
        longint unsigned ua;
        longint unsigned ub;
        longint unsigned r;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        if (ua > (64'd1 << 48)) ua = 64'd1 << 48;
        if (ub > (64'd1 << 26)) ub = 64'd1 << 26;
        r = (ua >> sh) * ub + (((ua & ((64'd1 << sh) - 1)) * ub) >> sh);
        if (r > (64'd1 << 56)) r = 64'd1 << 56;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint squash(longint s);
        longint          lim;
        longint          a;
        longint unsigned ix;
        lim = longint'(30) << FB;
        s = clip(s, -lim, lim);
        a = s < 0 ? -s : s;
        ix = (a * DEPTH + lim / 2) / lim;
        if (ix > DEPTH) ix = DEPTH;
        return s >= 0 ? longint'(sig_tab[ix]) : ONE - longint'(sig_tab[ix]);
    endfunction

    function automatic longint fire(int wi, int bi, longint a, longint b);
        return squash(qmul(net_w[wi], a, FB) + qmul(net_w[wi + 1], b, FB)
                      - net_b[bi]);
    endfunction

    function automatic void nudge(int wi, int bi, longint a, longint b, longint e);
        longint ke;
        ke = qmul(e, longint'(rate_k), 16);
        net_b[bi] = clip_w(net_b[bi] - ke);
        net_w[wi] = clip_w(net_w[wi] + qmul(ke, a, FB));
        net_w[wi + 1] = clip_w(net_w[wi + 1] + qmul(ke, b, FB));
    endfunction

    function automatic result_t step_network(logic [1:0] op, longint xa, longint xb,
                                             longint goal);
        longint  h_and;
        longint  h_or;
        longint  y;
        longint  e;
        longint  t_and;
        result_t r;
        e = 0;
        if (op == tlst_pkg::OP_LOAD)
        begin
            for (int i = 0; i < 6; i++) net_w[i] = clip_w(longint'(seed_w[i]));
            for (int i = 0; i < 3; i++) net_b[i] = ONE / 2;
            return '0;
        end
        h_and = fire(2, 1, xa, xb);
        h_or = fire(4, 2, xa, xb);
        y = fire(0, 0, h_and, h_or);
        if (op == tlst_pkg::OP_TRAIN)
        begin
            t_and = qmul(xa, xb, FB);
            nudge(2, 1, xa, xb, t_and - h_and);
            nudge(4, 2, xa, xb, xa + xb - t_and - h_or);
            e = goal - y;
            nudge(0, 0, h_and, h_or, e);
        end
        r.net = 17'(clip(y, 0, 17'h1FFFF));
        r.err = 18'(clip(e, -131072, 131071));
        return r;
    endfunction

    // request side monitor and prediction
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            result_t r;
            r = step_network(s_tuser, s_tdata[16:0], s_tdata[33:17], s_tdata[50:34]);
            if (cur_typed)
                r = cur_result;
            pending_results.push_back(r);
            req_count++;
            if (s_tuser == tlst_pkg::OP_TRAIN)
                train_count++;
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            result_t want;
            rsp_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[16:0] !== want.net)
                begin
                    $display("%0t: net_out expected %h actual %h", $time, want.net,
                             m_tdata[16:0]);
                    fail_count++;
                end
                if (m_tdata[34:17] !== want.err)
                begin
                    $display("%0t: out_error expected %h actual %h", $time, want.err,
                             m_tdata[34:17]);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        m_tready <= ((cyc % stall_mod) > 4) || ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_request(logic [1:0] op, logic [16:0] xa, logic [16:0] xb,
                                logic [16:0] goal, bit typed, result_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'b0, goal, xb, xa};
        cur_typed <= typed;
        cur_result <= r;
        do @(posedge clk); while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tlst_pkg::REG_LEARN_RATE)
            rate_k = val[15:0];
        else
            seed_w[idx - 1] = val;
        @(posedge clk);
    endtask

    function automatic logic [16:0] rand_x();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return 17'd0;
        if (pick == 1) return 17'd65536;
        if (pick == 2) return 17'($urandom);
        if (pick < 8) return $urandom_range(0, 1) ? 17'd65536 : 17'd0;
        return 17'($urandom_range(0, 65536));
    endfunction

    stim_row_t rows [$];

    function automatic stim_row_t mk(logic [1:0] op, logic [16:0] xa, logic [16:0] xb,
                                     logic [16:0] goal, bit typed);
        stim_row_t r;
        r.op = op;
        r.xa = xa;
        r.xb = xb;
        r.goal = goal;
        r.typed = typed;
        r.net = '0;
        r.err = '0;
        return r;
    endfunction

    initial
    begin
        result_t   none;
        logic [16:0] wv;
        int        pick;
        none = '0;
        fill_sig_tab();
        rate_k = 1966;
        for (int i = 0; i < 6; i++)
        begin
            seed_w[i] = 32768;
            net_w[i] = 0;
        end
        for (int i = 0; i < 3; i++) net_b[i] = ONE / 2;

        rows.push_back(mk(tlst_pkg::OP_INFER, 17'd0, 17'd0, 17'd0, 0));
        rows.push_back(mk(tlst_pkg::OP_TRAIN, 17'd65536, 17'd65536, 17'd65536, 0));
        rows.push_back(mk(tlst_pkg::OP_LOAD, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1));
        rows.push_back(mk(tlst_pkg::OP_INFER, 17'd0, 17'd0, 17'd0, 0));
        rows.push_back(mk(tlst_pkg::OP_INFER, 17'd65536, 17'd65536, 17'd0, 0));
        rows.push_back(mk(tlst_pkg::OP_TRAIN, 17'd0, 17'd0, 17'd0, 0));
        rows.push_back(mk(tlst_pkg::OP_TRAIN, 17'd65536, 17'd0, 17'd65536, 0));
        rows.push_back(mk(tlst_pkg::OP_TRAIN, 17'd0, 17'd65536, 17'd65536, 0));
        rows.push_back(mk(tlst_pkg::OP_TRAIN, 17'd65536, 17'd65536, 17'd65536, 0));
        rows.push_back(mk(tlst_pkg::OP_TRAIN, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 0));
        rows.push_back(mk(tlst_pkg::OP_TRAIN, 17'h1FFFF, 17'd0, 17'd0, 0));
        rows.push_back(mk(OP_SPARE, 17'd32768, 17'd65536, 17'h1FFFF, 0));
        rows.push_back(mk(tlst_pkg::OP_INFER, 17'h15555, 17'h0AAAA, 17'h1FFFF, 0));
        rows.push_back(mk(tlst_pkg::OP_LOAD, 17'd0, 17'd0, 17'd0, 1));
        rows.push_back(mk(tlst_pkg::OP_INFER, 17'd32768, 17'd32768, 17'd0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (rows[i])
        begin
            none.net = rows[i].net;
            none.err = rows[i].err;
            send_request(rows[i].op, rows[i].xa, rows[i].xb, rows[i].goal, rows[i].typed,
                         none);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            stall_mod = $urandom_range(6, 40);
            for (int k = 0; k < 7; k++)
            begin
                case (ph)
                    0: wv = (k == 0) ? 17'd65535 : 17'd65536;
                    1: wv = 17'd0;
                    2: wv = (k == 0) ? 17'd1966 : 17'h1FFFF;
                    default: wv = (k == 0) ? 17'($urandom_range(0, 65535))
                                           : 17'($urandom_range(0, 65536));
                endcase
                write_reg(3'(k), wv);
            end
            for (int n = 0; n < 230; n++)
            begin
                pick = $urandom_range(0, 99);
                send_request((n == 0 || pick < 6) ? tlst_pkg::OP_LOAD :
                             (pick < 66) ? tlst_pkg::OP_TRAIN :
                             (pick < 94) ? tlst_pkg::OP_INFER : OP_SPARE,
                             rand_x(), rand_x(),
                             ($urandom_range(0, 9) == 0) ? 17'($urandom) : rand_x(),
                             0, '0);
            end
        end
        drain();

        $display("Covered %0d requests (%0d training steps) and %0d results", req_count,
                 train_count, rsp_count);
        $display("across six learning-rate and initial-weight settings.");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tlst_pkg.sv
hw/rtl/tlst_sigmoid.sv
hw/rtl/tlst_lane.sv
hw/rtl/two_layer_sigmoid_trainer_core.sv
hw/rtl/tlst_checker.sv
tb/tb.sv
